@@ rtl/core/tcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and fixed widths of the triangle circumcircle block.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Width of one coordinate field on the input channel.
    localparam int IN_W = 16;
    // Width of the center and radius fields.
    localparam int OUT_W = 32;
    // Quotient bits kept by the divider; larger offsets count as huge.
    localparam int QUOT_BITS = 40;
    // Root bits, squared-sum width and remainder width of the square root.
    localparam int RAD_BITS = OUT_W + 1;
    localparam int SQ_W = 2 * OUT_W + 1;
    localparam int REM_W = SQ_W + 2;

    typedef logic signed [IN_W-1:0]  coord_field_t;
    typedef logic signed [OUT_W-1:0] center_t;
    typedef logic [OUT_W-1:0]        radius_t;

endpackage

@@ rtl/core/tcc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_in_if / tcc_out_if
// Valid/ready channels for triangles in and circumcircles out.
// ----------------------------------------------------------------------------
interface tcc_in_if;
    import tcc_pkg::*;

    logic         valid;
    logic         ready;
    coord_field_t first_x;
    coord_field_t first_y;
    coord_field_t second_x;
    coord_field_t second_y;
    coord_field_t third_x;
    coord_field_t third_y;

    modport source (output valid, output first_x, output first_y, output second_x,
                    output second_y, output third_x, output third_y, input ready);
    modport sink (input valid, input first_x, input first_y, input second_x,
                  input second_y, input third_x, input third_y, output ready);
endinterface

interface tcc_out_if;
    import tcc_pkg::*;

    logic    valid;
    logic    ready;
    logic    circle_valid;
    center_t center_x;
    center_t center_y;
    radius_t radius;

    modport source (output valid, output circle_valid, output center_x,
                    output center_y, output radius, input ready);
    modport sink (input valid, input circle_valid, input center_x,
                  input center_y, input radius, output ready);
endinterface

@@ rtl/core/triangle_circumcircle_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_top
// Circumcenter and circumradius of a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one triangle per clock cycle while the output is not
// stalled and returns one circle per triangle, in order. The pipeline is the
// 41-stage quotient pipeline (an input register and one quotient bit per
// stage, x and y in parallel) and the 34-stage square root (an input register
// and one root bit per stage), plus seven stages that form the edge
// differences, the products and the dividends, three that saturate the center
// and square the offsets, and the output register. Whenever the output
// register holds a circle that has not been taken, the whole pipeline holds;
// otherwise a new triangle is taken every cycle. Coordinates are the low
// COORD_BITS bits of each field, sign-extended. The center carries FRAC_BITS
// fractional bits, rounded to nearest with ties away from zero, and saturates
// to the 32-bit range; the radius is the floor of the distance from the first
// point to the rounded center and saturates to all ones. Collinear or
// coincident points give circle_valid low and zero center and radius.
// ----------------------------------------------------------------------------
module triangle_circumcircle_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input logic       clk,
    input logic       rst_n,
    tcc_in_if.sink    points,
    tcc_out_if.source circle
);
    import tcc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int AW   = CB + 1;                 // edge differences
    localparam int PW   = 2 * AW;                 // products and squared lengths
    localparam int GW   = PW + 1;                 // determinant term g
    localparam int LW   = PW / 2;                 // split point of the squared lengths
    localparam int PPW  = AW + LW + 1;            // partial products
    localparam int EW   = PPW + LW + 2;           // numerator sum before trimming
    localparam int NW   = 3 * CB + 3;             // numerators
    localparam int TW   = 3 * CB + FRAC_BITS + 4; // rounded dividend
    localparam int DW   = PW + 1;                 // divisor 2*|g|
    localparam int SUMW = CB + FRAC_BITS + QUOT_BITS + 3;
    localparam int XSW  = 2 * CB + 2;
    localparam int RSW  = 2 * OUT_W + 2;

    // A stalled output freezes every stage, so nothing is lost or repeated.
    logic en;
    assign en           = !circle.valid || circle.ready;
    assign points.ready = en;

    // ---------------- stage 1: coordinates and edge differences -------------
    logic signed [CB-1:0] px1, py1, px2, py2, px3, py3;
    assign px1 = signed'(CB'($unsigned(points.first_x)));
    assign py1 = signed'(CB'($unsigned(points.first_y)));
    assign px2 = signed'(CB'($unsigned(points.second_x)));
    assign py2 = signed'(CB'($unsigned(points.second_y)));
    assign px3 = signed'(CB'($unsigned(points.third_x)));
    assign py3 = signed'(CB'($unsigned(points.third_y)));

    logic                 v1_reg;
    logic signed [CB-1:0] x1_1_reg, y1_1_reg;
    logic signed [AW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;

    // ---------------- stage 2: products --------------------------------------
    logic                 v2_reg;
    logic signed [CB-1:0] x1_2_reg, y1_2_reg;
    logic signed [AW-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [PW-1:0] aa2_reg, bb2_reg, cc2_reg, dd2_reg, ad2_reg, bc2_reg;

    // ---------------- stage 3: squared lengths and g -------------------------
    logic                 v3_reg;
    logic signed [CB-1:0] x1_3_reg, y1_3_reg;
    logic signed [AW-1:0] a3_reg, b3_reg, c3_reg, d3_reg;
    logic [PW-1:0]        uu3_reg, vv3_reg;
    logic signed [GW-1:0] g3_reg;

    // ---------------- stage 4: split products of the numerators -------------
    logic                  v4_reg;
    logic signed [CB-1:0]  x1_4_reg, y1_4_reg;
    logic signed [PPW-1:0] pdl4_reg, pdh4_reg, pbl4_reg, pbh4_reg;
    logic signed [PPW-1:0] pal4_reg, pah4_reg, pcl4_reg, pch4_reg;
    logic                  gnz4_reg, gneg4_reg;
    logic [PW-1:0]         gm4_reg;

    // ---------------- stage 5: numerators ------------------------------------
    logic                 v5_reg;
    logic signed [CB-1:0] x1_5_reg, y1_5_reg;
    logic signed [NW-1:0] nx5_reg, ny5_reg;
    logic                 gnz5_reg, gneg5_reg;
    logic [PW-1:0]        gm5_reg;
    logic signed [EW-1:0] nx_wide, ny_wide;

    // ---------------- stage 6: magnitudes and quotient signs -----------------
    logic                 v6_reg;
    logic signed [CB-1:0] x1_6_reg, y1_6_reg;
    logic [NW-1:0]        magx6_reg, magy6_reg;
    logic                 negx6_reg, negy6_reg, gnz6_reg;
    logic [PW-1:0]        gm6_reg;

    // ---------------- stage 7: rounded dividends and divisor -----------------
    logic                 v7_reg;
    logic signed [CB-1:0] x1_7_reg, y1_7_reg;
    logic [TW-1:0]        tx7_reg, ty7_reg;
    logic [DW-1:0]        d7_reg;
    logic                 negx7_reg, negy7_reg, gnz7_reg;

    // Split points of the squared lengths for the partial products.
    logic [LW-1:0] uu_lo, uu_hi, vv_lo, vv_hi;
    assign uu_lo = uu3_reg[LW-1:0];
    assign uu_hi = uu3_reg[PW-1:LW];
    assign vv_lo = vv3_reg[LW-1:0];
    assign vv_hi = vv3_reg[PW-1:LW];

    always_comb
    begin
        nx_wide = (EW'(pdh4_reg) <<< LW) + EW'(pdl4_reg)
                - (EW'(pbh4_reg) <<< LW) - EW'(pbl4_reg);
        ny_wide = (EW'(pah4_reg) <<< LW) + EW'(pal4_reg)
                - (EW'(pch4_reg) <<< LW) - EW'(pcl4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            x1_1_reg <= px1;
            y1_1_reg <= py1;
            a1_reg   <= AW'(px2) - AW'(px1);
            b1_reg   <= AW'(py2) - AW'(py1);
            c1_reg   <= AW'(px3) - AW'(px1);
            d1_reg   <= AW'(py3) - AW'(py1);
            // stage 2
            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            d2_reg   <= d1_reg;
            aa2_reg  <= a1_reg * a1_reg;
            bb2_reg  <= b1_reg * b1_reg;
            cc2_reg  <= c1_reg * c1_reg;
            dd2_reg  <= d1_reg * d1_reg;
            ad2_reg  <= a1_reg * d1_reg;
            bc2_reg  <= b1_reg * c1_reg;
            // stage 3
            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            d3_reg   <= d2_reg;
            uu3_reg  <= $unsigned(aa2_reg) + $unsigned(bb2_reg);
            vv3_reg  <= $unsigned(cc2_reg) + $unsigned(dd2_reg);
            g3_reg   <= (GW'(ad2_reg) - GW'(bc2_reg)) <<< 1;
            // stage 4
            x1_4_reg  <= x1_3_reg;
            y1_4_reg  <= y1_3_reg;
            pdl4_reg  <= d3_reg * signed'({1'b0, uu_lo});
            pdh4_reg  <= d3_reg * signed'({1'b0, uu_hi});
            pbl4_reg  <= b3_reg * signed'({1'b0, vv_lo});
            pbh4_reg  <= b3_reg * signed'({1'b0, vv_hi});
            pal4_reg  <= a3_reg * signed'({1'b0, vv_lo});
            pah4_reg  <= a3_reg * signed'({1'b0, vv_hi});
            pcl4_reg  <= c3_reg * signed'({1'b0, uu_lo});
            pch4_reg  <= c3_reg * signed'({1'b0, uu_hi});
            gnz4_reg  <= (g3_reg != '0);
            gneg4_reg <= g3_reg[GW-1];
            gm4_reg   <= PW'(g3_reg[GW-1] ? -g3_reg : g3_reg);
            // stage 5
            x1_5_reg  <= x1_4_reg;
            y1_5_reg  <= y1_4_reg;
            nx5_reg   <= NW'(nx_wide);
            ny5_reg   <= NW'(ny_wide);
            gnz5_reg  <= gnz4_reg;
            gneg5_reg <= gneg4_reg;
            gm5_reg   <= gm4_reg;
            // stage 6
            x1_6_reg  <= x1_5_reg;
            y1_6_reg  <= y1_5_reg;
            magx6_reg <= nx5_reg[NW-1] ? $unsigned(-nx5_reg) : $unsigned(nx5_reg);
            magy6_reg <= ny5_reg[NW-1] ? $unsigned(-ny5_reg) : $unsigned(ny5_reg);
            negx6_reg <= nx5_reg[NW-1] ^ gneg5_reg;
            negy6_reg <= ny5_reg[NW-1] ^ gneg5_reg;
            gnz6_reg  <= gnz5_reg;
            gm6_reg   <= gm5_reg;
            // stage 7: (2*|n|*2^F + |g|) / (2*|g|) rounds to nearest, ties away
            x1_7_reg  <= x1_6_reg;
            y1_7_reg  <= y1_6_reg;
            tx7_reg   <= (TW'(magx6_reg) << (FRAC_BITS + 1)) + TW'(gm6_reg);
            ty7_reg   <= (TW'(magy6_reg) << (FRAC_BITS + 1)) + TW'(gm6_reg);
            d7_reg    <= {gm6_reg, 1'b0};
            negx7_reg <= negx6_reg;
            negy7_reg <= negy6_reg;
            gnz7_reg  <= gnz6_reg;
        end
    end

    // ---------------- dividers ----------------------------------------------
    logic                  dx_valid, dy_valid;
    logic [QUOT_BITS-1:0]  qx, qy;
    logic                  hx, hy;
    logic [XSW-1:0]        xside;
    logic [0:0]            yside;
    logic                  gnz_d, negx_d, negy_d;
    logic signed [CB-1:0]  x1_d, y1_d;

    tcc_div #(.DW(DW), .TW(TW), .SIDE_W(XSW)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .dividend  (tx7_reg),
        .divisor   (d7_reg),
        .side_in   ({gnz7_reg, negx7_reg, x1_7_reg, y1_7_reg}),
        .out_valid (dx_valid),
        .quot      (qx),
        .huge      (hx),
        .side_out  (xside)
    );

    tcc_div #(.DW(DW), .TW(TW), .SIDE_W(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .dividend  (ty7_reg),
        .divisor   (d7_reg),
        .side_in   (negy7_reg),
        .out_valid (dy_valid),
        .quot      (qy),
        .huge      (hy),
        .side_out  (yside)
    );

    assign gnz_d  = xside[XSW-1];
    assign negx_d = xside[XSW-2];
    assign x1_d   = signed'(xside[2*CB-1:CB]);
    assign y1_d   = signed'(xside[CB-1:0]);
    assign negy_d = yside[0];

    // ---------------- center and offset magnitudes --------------------------
    // A huge offset saturates toward its sign; otherwise the scaled first point
    // plus the rounded offset is clamped to the 32-bit range.
    function automatic center_t sat_center(input logic signed [SUMW-1:0] v,
                                           input logic is_huge, input logic neg);
        logic fits;
        center_t r;
        fits = (v[SUMW-1:OUT_W-1] == '0) || (v[SUMW-1:OUT_W-1] == '1);
        if (is_huge)
            r = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else if (fits)
            r = v[OUT_W-1:0];
        else
            r = v[SUMW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

    logic signed [SUMW-1:0] offx, offy, sumx, sumy;
    always_comb
    begin
        offx = negx_d ? -signed'(SUMW'(qx)) : signed'(SUMW'(qx));
        offy = negy_d ? -signed'(SUMW'(qy)) : signed'(SUMW'(qy));
        sumx = (SUMW'(x1_d) <<< FRAC_BITS) + offx;
        sumy = (SUMW'(y1_d) <<< FRAC_BITS) + offy;
    end

    logic             vp1_reg, vp2_reg, vp3_reg;
    center_t          cx1_reg, cy1_reg, cx2_reg, cy2_reg, cx3_reg, cy3_reg;
    logic             rsat1_reg, rsat2_reg, rsat3_reg;
    logic             gnz_p1_reg, gnz_p2_reg, gnz_p3_reg;
    logic [OUT_W-1:0] mx1_reg, my1_reg;
    logic [2*OUT_W-1:0] sqx2_reg, sqy2_reg;
    logic [SQ_W-1:0]  sum3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx1_reg    <= sat_center(sumx, hx, negx_d);
            cy1_reg    <= sat_center(sumy, hy, negy_d);
            rsat1_reg  <= hx || hy || (|qx[QUOT_BITS-1:OUT_W]) || (|qy[QUOT_BITS-1:OUT_W]);
            mx1_reg    <= qx[OUT_W-1:0];
            my1_reg    <= qy[OUT_W-1:0];
            gnz_p1_reg <= gnz_d;

            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            rsat2_reg  <= rsat1_reg;
            gnz_p2_reg <= gnz_p1_reg;
            sqx2_reg   <= mx1_reg * mx1_reg;
            sqy2_reg   <= my1_reg * my1_reg;

            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            rsat3_reg  <= rsat2_reg;
            gnz_p3_reg <= gnz_p2_reg;
            sum3_reg   <= SQ_W'(sqx2_reg) + SQ_W'(sqy2_reg);
        end
    end

    // ---------------- square root -------------------------------------------
    logic                r_valid;
    logic [RAD_BITS-1:0] root;
    logic [RSW-1:0]      rside;
    logic                gnz_r, rsat_r;
    center_t             cx_r, cy_r;

    tcc_sqrt #(.SIDE_W(RSW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp3_reg),
        .sq_sum    (sum3_reg),
        .side_in   ({gnz_p3_reg, rsat3_reg, cx3_reg, cy3_reg}),
        .out_valid (r_valid),
        .root      (root),
        .side_out  (rside)
    );

    assign gnz_r  = rside[RSW-1];
    assign rsat_r = rside[RSW-2];
    assign cx_r   = signed'(rside[2*OUT_W-1:OUT_W]);
    assign cy_r   = signed'(rside[OUT_W-1:0]);

    // ---------------- output register ----------------------------------------
    logic    vo_reg;
    logic    cv_reg;
    center_t ocx_reg, ocy_reg;
    radius_t orad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cv_reg   <= gnz_r;
            ocx_reg  <= gnz_r ? cx_r : '0;
            ocy_reg  <= gnz_r ? cy_r : '0;
            if (!gnz_r)
                orad_reg <= '0;
            else if (rsat_r || root[RAD_BITS-1])
                orad_reg <= '1;
            else
                orad_reg <= root[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= points.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            vp1_reg <= dx_valid;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
            vo_reg  <= r_valid;
        end
    end

    assign circle.valid        = vo_reg;
    assign circle.circle_valid = cv_reg;
    assign circle.center_x     = ocx_reg;
    assign circle.center_y     = ocy_reg;
    assign circle.radius       = orad_reg;

    // ---------------- assertions ---------------------------------------------
    // A degenerate triangle always reports an all-zero circle.
    assert property (@(posedge clk) disable iff (!rst_n)
        circle.valid && !circle.circle_valid |->
            circle.center_x == 0 && circle.center_y == 0 && circle.radius == 0)
        else $error("degenerate circle has nonzero fields");

    // An accepted transaction occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready |=> v1_reg)
        else $error("accepted triangle missing from first stage");

    // The two dividers run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n)
        dx_valid == dy_valid)
        else $error("x and y dividers out of step");

    // A stall freezes the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg) && $stable(vp3_reg) && $stable(r_valid))
        else $error("pipeline moved during a stall");

endmodule

@@ rtl/core/tcc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module tcc_div #(
    parameter int DW     = 35,
    parameter int TW     = 60,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [TW-1:0]     dividend,
    input  logic [DW-1:0]     divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [tcc_pkg::QUOT_BITS-1:0] quot,
    output logic              huge,
    output logic [SIDE_W-1:0] side_out
);
    import tcc_pkg::*;

    localparam int QB = QUOT_BITS;
    localparam int CW = TW + QB + DW;

    logic              v_reg [0:QB];
    logic [QB-1:0]     q_reg [0:QB];
    logic              h_reg [0:QB];
    logic [SIDE_W-1:0] s_reg [0:QB];
    logic [DW:0]       r_reg [0:QB-1];
    logic [QB-1:0]     tl_reg[0:QB-1];
    logic [DW-1:0]     d_reg [0:QB-1];

    // The quotient fits in QB bits exactly when the dividend is below divisor * 2^QB.
    logic huge_next;
    assign huge_next = (CW'(dividend) >= (CW'(divisor) << QB));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]  <= '0;
            h_reg[0]  <= huge_next;
            s_reg[0]  <= side_in;
            r_reg[0]  <= (DW+1)'(dividend >> QB);
            tl_reg[0] <= dividend[QB-1:0];
            d_reg[0]  <= divisor;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW:0] shifted;
        logic        ge;

        assign shifted = {r_reg[k][DW-1:0], tl_reg[k][QB-1]};
        assign ge      = (shifted >= {1'b0, d_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1] <= {q_reg[k][QB-2:0], ge};
                h_reg[k+1] <= h_reg[k];
                s_reg[k+1] <= s_reg[k];
            end
        end

        if (k < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1]  <= ge ? (shifted - {1'b0, d_reg[k]}) : shifted;
                    tl_reg[k+1] <= tl_reg[k] << 1;
                    d_reg[k+1]  <= d_reg[k];
                end
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quot      = q_reg[QB];
    assign huge      = h_reg[QB];
    assign side_out  = s_reg[QB];

endmodule

@@ rtl/core/tcc_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tcc_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [tcc_pkg::SQ_W-1:0] sq_sum,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [tcc_pkg::RAD_BITS-1:0] root,
    output logic [SIDE_W-1:0] side_out
);
    import tcc_pkg::*;

    localparam int RB = RAD_BITS;

    logic              v_reg  [0:RB];
    logic [RB-1:0]     res_reg[0:RB];
    logic [SIDE_W-1:0] s_reg  [0:RB];
    logic [REM_W-1:0]  rem_reg[0:RB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg[0] <= '0;
            rem_reg[0] <= REM_W'(sq_sum);
            s_reg[0]   <= side_in;
        end
    end

    for (genvar j = 0; j < RB; j++)
    begin : g_step
        localparam int BP = RB - 1 - j;
        logic [REM_W-1:0] trial;
        logic             take;

        // (root + 2^BP)^2 - root^2 = root * 2^(BP+1) + 2^(2*BP).
        assign trial = (REM_W'(res_reg[j]) << (BP + 1)) | (REM_W'(1) << (2 * BP));
        assign take  = (trial <= rem_reg[j]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[j+1] <= take ? (res_reg[j] | (RB'(1) << BP)) : res_reg[j];
                s_reg[j+1]   <= s_reg[j];
            end
        end

        if (j < RB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= take ? (rem_reg[j] - trial) : rem_reg[j];
                end
            end
        end
    end

    assign out_valid = v_reg[RB];
    assign root      = res_reg[RB];
    assign side_out  = s_reg[RB];

endmodule

@@ bench/triangle_circumcircle_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_top_tb
// Self-checking bench for the triangle circumcircle pipeline.
// ----------------------------------------------------------------------------
// Triangles go in on a valid/ready channel with random gaps. A local integer
// model predicts each circle: center rounded to nearest with ties away from
// zero, saturated, and a floor square root for the radius. Circles coming out
// are compared in order against the predictions.
// ----------------------------------------------------------------------------
module triangle_circumcircle_top_tb;
    import tcc_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int RANDOM_TRIS = 1750;
    localparam int STALL_LEN   = 400;
    localparam int DOG_LIMIT   = 3000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        coord_field_t x1, y1, x2, y2, x3, y3;
    } triangle_t;

    typedef struct {
        logic    ok;
        center_t cx;
        center_t cy;
        radius_t r;
    } circle_t;

    // Scoreboard: turns each accepted triangle into the circle it must give,
    // and checks circles against the oldest pending prediction.
    class circle_board;
        circle_t pending[$];
        int      errors;
        int      checked;
        int      degenerate;
        int      saturated;

        function longint rounded_offset(longint num, longint g, output bit huge);
            bit     neg;
            longint mag;
            longint gm;
            longint q;
            neg  = (num < 0) ^ (g < 0);
            mag  = (num < 0) ? -num : num;
            gm   = (g < 0) ? -g : g;
            q    = ((mag <<< (FRAC_BITS + 1)) + gm) / (2 * gm);
            huge = (q >= (64'sd1 <<< 40));
            if (huge)
                return neg ? -1 : 1;
            return neg ? -q : q;
        endfunction

        function center_t place_center(longint base, longint off, bit huge);
            longint v;
            if (huge)
                v = (off < 0) ? -64'sd2147483648 : 64'sd2147483647;
            else
                v = base * (64'sd1 <<< FRAC_BITS) + off;
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return center_t'(v);
        endfunction

        function radius_t distance(longint ox, longint oy, bit huge);
            logic [63:0]  mx, my, root, cand;
            logic [127:0] sum;
            mx = (ox < 0) ? -ox : ox;
            my = (oy < 0) ? -oy : oy;
            if (huge || mx >= 64'h1_0000_0000 || my >= 64'h1_0000_0000)
                return '1;
            sum  = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
            root = '0;
            for (int i = 32; i >= 0; i--)
            begin
                cand = root | (64'd1 << i);
                if (128'(cand) * 128'(cand) <= sum)
                    root = cand;
            end
            return (root > 64'hFFFF_FFFF) ? '1 : radius_t'(root);
        endfunction

        function circle_t circumcircle(triangle_t t);
            longint  x1, y1, a, b, c, d, g, uu, vv, nx, ny, ox, oy;
            bit      hx, hy;
            circle_t res;
            x1 = t.x1;
            y1 = t.y1;
            a  = longint'(t.x2) - x1;
            b  = longint'(t.y2) - y1;
            c  = longint'(t.x3) - x1;
            d  = longint'(t.y3) - y1;
            g  = 2 * (a * d - b * c);
            res = '{1'b0, '0, '0, '0};
            if (g == 0)
                return res;
            uu     = a * a + b * b;
            vv     = c * c + d * d;
            nx     = d * uu - b * vv;
            ny     = a * vv - c * uu;
            ox     = rounded_offset(nx, g, hx);
            oy     = rounded_offset(ny, g, hy);
            res.ok = 1'b1;
            res.cx = place_center(x1, ox, hx);
            res.cy = place_center(y1, oy, hy);
            res.r  = distance(ox, oy, hx || hy);
            return res;
        endfunction

        function void note_triangle(triangle_t t);
            circle_t e;
            e = circumcircle(t);
            if (!e.ok)
                degenerate++;
            else if (e.r == '1)
                saturated++;
            pending.push_back(e);
        endfunction

        function void check_circle(circle_t got);
            circle_t e;
            if (pending.size() == 0)
            begin
                $error("circle arrived with no triangle pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.ok !== e.ok)
            begin
                $error("circle_valid: expected %0d, got %0d", e.ok, got.ok);
                errors++;
            end
            if (got.cx !== e.cx)
            begin
                $error("center_x: expected %0d, got %0d", e.cx, got.cx);
                errors++;
            end
            if (got.cy !== e.cy)
            begin
                $error("center_y: expected %0d, got %0d", e.cy, got.cy);
                errors++;
            end
            if (got.r !== e.r)
            begin
                $error("radius: expected %0d, got %0d", e.r, got.r);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tcc_in_if  points_if();
    tcc_out_if circle_if();

    triangle_circumcircle_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .points(points_if),
        .circle(circle_if)
    );

    circle_board board;
    int          sent;
    bit          no_idle;     // When set, neither side inserts gaps.
    bit          hold_output; // Request for one long stall of the receiver.
    int          quiet_cycles;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_length();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_field_t any_coord();
        return coord_field_t'($urandom);
    endfunction

    function automatic coord_field_t near(coord_field_t base, int span);
        int v;
        v = int'(base) + $urandom_range(0, 2 * span) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_field_t'(v);
    endfunction

    // Builds one random triangle. The mix covers full-range points, small
    // triangles, nearly collinear ones that push the center to saturation,
    // and exactly collinear or coincident ones.
    function automatic triangle_t random_triangle();
        triangle_t t;
        int        kind;
        int        dx, dy, k;
        kind = $urandom_range(0, 99);
        t.x1 = any_coord();
        t.y1 = any_coord();
        if (kind < 40)
        begin
            t.x2 = any_coord();
            t.y2 = any_coord();
            t.x3 = any_coord();
            t.y3 = any_coord();
        end
        else if (kind < 70)
        begin
            t.x2 = near(t.x1, 60);
            t.y2 = near(t.y1, 60);
            t.x3 = near(t.x1, 60);
            t.y3 = near(t.y1, 60);
        end
        else
        begin
            t.x2 = near(t.x1, 200);
            t.y2 = near(t.y1, 200);
            dx   = int'(t.x2) - int'(t.x1);
            dy   = int'(t.y2) - int'(t.y1);
            k    = $urandom_range(0, 6) - 3;
            t.x3 = near(coord_field_t'(int'(t.x1) + k * dx), 0);
            t.y3 = near(coord_field_t'(int'(t.y1) + k * dy), 0);
            // Nearly collinear: nudge the third point by up to one step.
            if (kind < 85)
                t.y3 = near(t.y3, 1);
        end
        return t;
    endfunction

    // Offers one triangle and waits until it is accepted. Valid is only
    // lowered when a gap precedes the transaction, so it never toggles
    // within one time step.
    task automatic send_triangle(triangle_t t);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            points_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        points_if.valid    <= 1'b1;
        points_if.first_x  <= t.x1;
        points_if.first_y  <= t.y1;
        points_if.second_x <= t.x2;
        points_if.second_y <= t.y2;
        points_if.third_x  <= t.x3;
        points_if.third_y  <= t.y3;
        do
            @(posedge clk);
        while (!points_if.ready);
        board.note_triangle(t);
        sent++;
        @(negedge clk);
    endtask

    // Withdraws the offer, then waits until every outstanding circle is
    // back.
    task automatic wait_drained();
        points_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending.size() != 0);
    endtask

    // Receiver side: random back-pressure, plus one long stall on request
    // that lets the pipeline fill and stall the input.
    initial
    begin
        int gap;
        circle_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                circle_if.ready <= 1'b0;
                repeat (STALL_LEN) @(negedge clk);
                hold_output = 1'b0;
            end
            gap = gap_length();
            if (gap > 0)
            begin
                circle_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            circle_if.ready <= 1'b1;
        end
    end

    // Output monitor: every circle transaction is checked at the rising edge.
    always @(posedge clk)
    begin
        circle_t got;
        if (rst_n && circle_if.valid && circle_if.ready)
        begin
            got.ok = circle_if.circle_valid;
            got.cx = circle_if.center_x;
            got.cy = circle_if.center_y;
            got.r  = circle_if.radius;
            board.check_circle(got);
        end
    end

    // Watchdog: while circles are outstanding, any stretch without a transaction
    // on either side that outlasts the longest legal stall ends the run.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            quiet_cycles <= 0;
        else if ((points_if.valid && points_if.ready) || (circle_if.valid && circle_if.ready)
            || board.pending.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT)
        begin
            $display("Watchdog expired with %0d circles outstanding.", board.pending.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        triangle_t directed[$];
        board              = new();
        sent               = 0;
        no_idle            = 1'b0;
        hold_output        = 1'b0;
        quiet_cycles       = 0;
        rst_n              = 1'b0;
        points_if.valid    = 1'b0;
        points_if.first_x  = '0;
        points_if.first_y  = '0;
        points_if.second_x = '0;
        points_if.second_y = '0;
        points_if.third_x  = '0;
        points_if.third_y  = '0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed triangles: coincident points, collinear lines, the
        // coordinate corners, small exact cases and saturating centers.
        directed.push_back('{0, 0, 0, 0, 0, 0});
        directed.push_back('{5, 5, 5, 5, 5, 5});
        directed.push_back('{0, 0, 1, 1, 2, 2});
        directed.push_back('{-32768, -32768, 32767, 32767, 0, 0});
        directed.push_back('{0, 0, 2, 0, 0, 2});
        directed.push_back('{0, 0, 1, 0, 0, 1});
        directed.push_back('{0, 0, 3, 0, 0, 1});
        directed.push_back('{1, 1, -1, 1, 0, 4});
        directed.push_back('{-32768, -32768, 32767, -32768, -32768, 32767});
        directed.push_back('{32767, 32767, -32768, 32767, 32767, -32768});
        directed.push_back('{-32768, 32767, 32767, 32767, 0, -32768});
        directed.push_back('{-32768, -32768, 32767, 32767, 32767, 32766});
        directed.push_back('{32767, 32767, -32768, -32768, -32768, -32767});
        directed.push_back('{-32768, -32768, 32767, 32766, 32766, 32765});
        directed.push_back('{0, 0, 32767, 1, -32768, 0});
        directed.push_back('{-1, -1, -1, 0, 0, -1});
        directed.push_back('{32767, 0, -32768, 0, 0, 1});
        directed.push_back('{100, -200, 100, 300, -400, -200});
        directed.push_back('{-5, 7, 9, -3, 2, 11});
        directed.push_back('{-21846, 21845, -1, -1, 21845, -21846});
        foreach (directed[i])
            send_triangle(directed[i]);
        wait_drained();

        for (int n = 0; n < RANDOM_TRIS; n++)
        begin
            // Let the receiver stall long enough for the pipeline to fill.
            if (n == 400)
                hold_output = 1'b1;
            // Pause the input until every outstanding circle is back.
            if (n == 900)
                wait_drained();
            no_idle = (n >= 1100 && n < 1350);
            send_triangle(random_triangle());
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Sent %0d triangles and checked %0d circles.", sent, board.checked);
        $display("Collinear results: %0d, saturated radii: %0d.",
                 board.degenerate, board.saturated);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
